// ===== sv/owrtm_pkg.sv =====
package owrtm_pkg;

  // configuration port shape
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_TICK_W  = 10;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_CODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_SAMPLE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POST_PRESENCE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LOW      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_LOW       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_SAMPLE    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_GAP       = 3'd7;

  // reset values of the registers
  localparam logic [7:0]            RST_COMMAND_CODE    = 8'd51;
  localparam logic [CFG_TICK_W-1:0] RST_RESET_LOW       = 10'd607;
  localparam logic [CFG_TICK_W-1:0] RST_PRESENCE_SAMPLE = 10'd50;
  localparam logic [CFG_TICK_W-1:0] RST_POST_PRESENCE   = 10'd580;
  localparam logic [CFG_TICK_W-1:0] RST_SHORT_LOW       = 10'd7;
  localparam logic [CFG_TICK_W-1:0] RST_LONG_LOW        = 10'd63;
  localparam logic [CFG_TICK_W-1:0] RST_READ_SAMPLE     = 10'd20;
  localparam logic [CFG_TICK_W-1:0] RST_BYTE_GAP        = 10'd320;

  // fixed timing
  localparam int CMD_GAP_TICKS   = 140;
  localparam int READ_TAIL_TICKS = 50;

  // response length and default tick counter width
  localparam int NUM_BYTES       = 8;
  localparam int TICK_WIDTH_DEF  = 10;

  typedef struct packed {
    logic [7:0]            command_code;
    logic [CFG_TICK_W-1:0] reset_low_ticks;
    logic [CFG_TICK_W-1:0] presence_sample_ticks;
    logic [CFG_TICK_W-1:0] post_presence_ticks;
    logic [CFG_TICK_W-1:0] short_low_ticks;
    logic [CFG_TICK_W-1:0] long_low_ticks;
    logic [CFG_TICK_W-1:0] read_sample_ticks;
    logic [CFG_TICK_W-1:0] byte_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [2:0] byte_index;
    logic       done_res;
    logic       present;
  } result_t;

endpackage

// ===== sv/owrtm_if.sv =====
// input channel: one tick with start request and line sample
interface owrtm_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic bus_level;

  modport source (output valid, output start_req, output bus_level, input ready);
  modport sink   (input valid, input start_req, input bus_level, output ready);
endinterface

// output channel: one result per tick
interface owrtm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic [2:0] byte_index;
  logic       done_res;
  logic       present;

  modport source (output valid, output drive_low, output busy_res, output byte_valid,
                  output byte_value, output byte_index, output done_res,
                  output present, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input byte_valid,
                  input byte_value, input byte_index, input done_res,
                  input present, output ready);
endinterface

// ===== sv/owrtm_fsm.sv =====
module owrtm_fsm
  import owrtm_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    start_req,
  input  logic    bus_level,
  input  cfg_t    cfg,
  output result_t res
);

  // compare width covers both the counter and the register fields
  localparam int CW = (TICK_WIDTH > CFG_TICK_W) ? TICK_WIDTH : CFG_TICK_W;
  localparam logic [CW-1:0] TMAX = CW'({TICK_WIDTH{1'b1}});
  localparam logic [TICK_WIDTH-1:0] TICK_ONE = TICK_WIDTH'(1);
  localparam logic [2:0] LAST_BYTE = 3'(NUM_BYTES - 1);

  // phase codes
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_RST   = 4'd1;
  localparam logic [3:0] PH_PRES  = 4'd2;
  localparam logic [3:0] PH_POST  = 4'd3;
  localparam logic [3:0] PH_WLOW  = 4'd4;
  localparam logic [3:0] PH_WHIGH = 4'd5;
  localparam logic [3:0] PH_CGAP  = 4'd6;
  localparam logic [3:0] PH_RLOW  = 4'd7;
  localparam logic [3:0] PH_RWAIT = 4'd8;
  localparam logic [3:0] PH_RTAIL = 4'd9;
  localparam logic [3:0] PH_BGAP  = 4'd10;

  logic [3:0]            phase, phase_next;
  logic [TICK_WIDTH-1:0] tick_count, tick_count_next;
  logic [2:0]            bit_count, bit_count_next;
  logic [2:0]            byte_count, byte_count_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic                  present_flag, present_flag_next;

  logic [CFG_TICK_W-1:0] len_raw;
  logic [CW-1:0]         len_ext, len_lim;
  logic                  waiting;
  logic                  cmd_bit;
  logic [7:0]            shift_in;
  logic [TICK_WIDTH-1:0] tick_inc;
  logic                  started;

  function automatic logic [CFG_TICK_W-1:0] at_least1(input logic [CFG_TICK_W-1:0] v);
    return (v == '0) ? CFG_TICK_W'(1) : v;
  endfunction

  // length of the current phase, forced to at least one where needed, then clipped
  assign cmd_bit = cfg.command_code[bit_count];

  always_comb begin
    len_ext = '0;
    len_raw = '0;
    case (phase)
      PH_RST:   len_raw = at_least1(cfg.reset_low_ticks);
      PH_PRES:  len_raw = at_least1(cfg.presence_sample_ticks);
      PH_POST:  len_raw = cfg.post_presence_ticks;
      PH_WLOW:  len_raw = at_least1(cmd_bit ? cfg.short_low_ticks : cfg.long_low_ticks);
      PH_WHIGH: len_raw = at_least1(cmd_bit ? cfg.long_low_ticks : cfg.short_low_ticks);
      PH_RLOW:  len_raw = at_least1(cfg.short_low_ticks);
      PH_RWAIT: len_raw = cfg.read_sample_ticks;
      PH_BGAP:  len_raw = cfg.byte_gap_ticks;
      default:  len_raw = '0;
    endcase
    case (phase)
      PH_CGAP:  len_ext = CW'(CMD_GAP_TICKS);
      PH_RTAIL: len_ext = CW'(READ_TAIL_TICKS);
      default:  len_ext = CW'(len_raw);
    endcase
  end

  assign len_lim  = (len_ext > TMAX) ? TMAX : len_ext;
  assign waiting  = CW'(tick_count) < len_lim;
  assign tick_inc = tick_count + TICK_ONE;
  assign shift_in = {bus_level, shift_byte[7:1]};

  // one tick: the current phase either waits or hands over, and zero-length
  // waits that follow are passed through in the same tick
  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_count_next    = bit_count;
    byte_count_next   = byte_count;
    shift_byte_next   = shift_byte;
    present_flag_next = present_flag;
    res               = '0;
    started           = (phase != PH_IDLE);

    case (phase)
      PH_RST: begin
        if (waiting) begin
          tick_count_next = tick_inc;
          res.drive_low   = 1'b1;
        end else begin
          phase_next      = PH_PRES;
          tick_count_next = TICK_ONE;
        end
      end
      PH_PRES: begin
        if (waiting) begin
          tick_count_next = tick_inc;
        end else begin
          present_flag_next = ~bus_level;
          if (bus_level) begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
            res.done_res    = 1'b1;
          end else if (cfg.post_presence_ticks == '0) begin
            bit_count_next  = '0;
            phase_next      = PH_WLOW;
            tick_count_next = TICK_ONE;
            res.drive_low   = 1'b1;
          end else begin
            phase_next      = PH_POST;
            tick_count_next = TICK_ONE;
          end
        end
      end
      PH_POST: begin
        if (waiting) begin
          tick_count_next = tick_inc;
        end else begin
          bit_count_next  = '0;
          phase_next      = PH_WLOW;
          tick_count_next = TICK_ONE;
          res.drive_low   = 1'b1;
        end
      end
      PH_WLOW: begin
        if (waiting) begin
          tick_count_next = tick_inc;
          res.drive_low   = 1'b1;
        end else begin
          phase_next      = PH_WHIGH;
          tick_count_next = TICK_ONE;
        end
      end
      PH_WHIGH: begin
        if (waiting) begin
          tick_count_next = tick_inc;
        end else begin
          bit_count_next  = bit_count + 3'd1;
          tick_count_next = TICK_ONE;
          if (bit_count == 3'd7) begin
            phase_next = PH_CGAP;
          end else begin
            phase_next    = PH_WLOW;
            res.drive_low = 1'b1;
          end
        end
      end
      PH_CGAP: begin
        if (waiting) begin
          tick_count_next = tick_inc;
        end else begin
          bit_count_next  = '0;
          byte_count_next = '0;
          shift_byte_next = '0;
          phase_next      = PH_RLOW;
          tick_count_next = TICK_ONE;
          res.drive_low   = 1'b1;
        end
      end
      PH_RLOW, PH_RWAIT: begin
        if (waiting) begin
          tick_count_next = tick_inc;
          res.drive_low   = (phase == PH_RLOW);
        end else if (phase == PH_RLOW && cfg.read_sample_ticks != '0) begin
          phase_next      = PH_RWAIT;
          tick_count_next = TICK_ONE;
        end else begin
          // sample the line and close the bit
          shift_byte_next = shift_in;
          bit_count_next  = bit_count + 3'd1;
          phase_next      = PH_RTAIL;
          tick_count_next = TICK_ONE;
          if (bit_count == 3'd7) begin
            res.byte_valid = 1'b1;
            res.byte_value = shift_in;
            res.byte_index = byte_count;
          end
        end
      end
      PH_RTAIL, PH_BGAP: begin
        if (waiting) begin
          tick_count_next = tick_inc;
        end else if (phase == PH_RTAIL && bit_count != '0) begin
          phase_next      = PH_RLOW;
          tick_count_next = TICK_ONE;
          res.drive_low   = 1'b1;
        end else if (phase == PH_RTAIL && cfg.byte_gap_ticks != '0) begin
          phase_next      = PH_BGAP;
          tick_count_next = TICK_ONE;
        end else if (byte_count == LAST_BYTE) begin
          // end of the byte gap, or of the read tail if there is no gap, on the last byte
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          res.done_res    = 1'b1;
        end else begin
          byte_count_next = byte_count + 3'd1;
          shift_byte_next = '0;
          phase_next      = PH_RLOW;
          tick_count_next = TICK_ONE;
          res.drive_low   = 1'b1;
        end
      end
      default: begin
        // idle: a start request opens the reset pulse in this tick
        phase_next = PH_IDLE;
        if (start_req) begin
          phase_next      = PH_RST;
          tick_count_next = TICK_ONE;
          bit_count_next  = '0;
          byte_count_next = '0;
          started         = 1'b1;
          res.drive_low   = 1'b1;
        end
      end
    endcase

    res.busy_res = started || res.done_res || (phase_next != PH_IDLE);
    res.present  = present_flag_next;
  end

  // state registers, stepped once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      bit_count    <= '0;
      byte_count   <= '0;
      shift_byte   <= '0;
      present_flag <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_count    <= bit_count_next;
      byte_count   <= byte_count_next;
      shift_byte   <= shift_byte_next;
      present_flag <= present_flag_next;
    end
  end

  // a start taken in idle always lands in the reset pulse
  a_start_to_reset: assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_IDLE && start_req |=> phase == PH_RST)
    else $error("start in idle did not enter reset pulse");

  // a finishing tick leaves the sequencer idle
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    advance && res.done_res |=> phase == PH_IDLE)
    else $error("done without return to idle");

  // a completed byte leaves the bit counter at the start of the next byte
  a_byte_wraps_bits: assert property (@(posedge clk) disable iff (rst)
    advance && res.byte_valid |=> bit_count == 3'd0 && phase == PH_RTAIL)
    else $error("byte completed with bits pending");

  // the line is never pulled low outside a transaction
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    advance && res.drive_low |-> res.busy_res && !res.done_res)
    else $error("line driven outside a transaction");

endmodule

// ===== sv/one_wire_read_transaction_master_unit.sv =====
// channel   dir  handshake      payload
// in_ch     in   valid/ready    start_req, bus_level (one microsecond tick)
// out_ch    out  valid/ready    drive_low, busy_res, byte_valid, byte_value,
//                               byte_index, done_res, present
// cfg_*     in   cfg_write      cfg_index selects register, cfg_data value
//
// one tick is taken per clock cycle; its result appears in the output register
// on the next cycle, set by the single pass through the phase sequencer
// rst (synchronous) returns the sequencer to idle and loads register defaults
// a stalled output holds its result, and a new tick is taken in the cycle the
// held result is taken
module one_wire_read_transaction_master_unit
  import owrtm_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  owrtm_in_if.sink               in_ch,
  owrtm_out_if.source            out_ch,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  result_t step_res;
  result_t out_q;
  logic    out_valid;
  logic    take;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.command_code          <= RST_COMMAND_CODE;
      cfg.reset_low_ticks       <= RST_RESET_LOW;
      cfg.presence_sample_ticks <= RST_PRESENCE_SAMPLE;
      cfg.post_presence_ticks   <= RST_POST_PRESENCE;
      cfg.short_low_ticks       <= RST_SHORT_LOW;
      cfg.long_low_ticks        <= RST_LONG_LOW;
      cfg.read_sample_ticks     <= RST_READ_SAMPLE;
      cfg.byte_gap_ticks        <= RST_BYTE_GAP;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COMMAND_CODE:    cfg.command_code          <= cfg_data[7:0];
        REG_RESET_LOW:       cfg.reset_low_ticks       <= cfg_data[CFG_TICK_W-1:0];
        REG_PRESENCE_SAMPLE: cfg.presence_sample_ticks <= cfg_data[CFG_TICK_W-1:0];
        REG_POST_PRESENCE:   cfg.post_presence_ticks   <= cfg_data[CFG_TICK_W-1:0];
        REG_SHORT_LOW:       cfg.short_low_ticks       <= cfg_data[CFG_TICK_W-1:0];
        REG_LONG_LOW:        cfg.long_low_ticks        <= cfg_data[CFG_TICK_W-1:0];
        REG_READ_SAMPLE:     cfg.read_sample_ticks     <= cfg_data[CFG_TICK_W-1:0];
        REG_BYTE_GAP:        cfg.byte_gap_ticks        <= cfg_data[CFG_TICK_W-1:0];
        default:             cfg.command_code          <= cfg.command_code;
      endcase
    end
  end

  // accept a tick whenever the output register is free or being emptied
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  owrtm_fsm #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_fsm (
    .clk       (clk),
    .rst       (rst),
    .advance   (take),
    .start_req (in_ch.start_req),
    .bus_level (in_ch.bus_level),
    .cfg       (cfg),
    .res       (step_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_q <= step_res;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.drive_low  = out_q.drive_low;
  assign out_ch.busy_res   = out_q.busy_res;
  assign out_ch.byte_valid = out_q.byte_valid;
  assign out_ch.byte_value = out_q.byte_value;
  assign out_ch.byte_index = out_q.byte_index;
  assign out_ch.done_res   = out_q.done_res;
  assign out_ch.present    = out_q.present;

endmodule
